[rtl/core/rscm_pkg.sv]
// Shared types, widths and constant tables of the range sensor collision monitor.
`timescale 1ns / 1ps

package rscm_pkg;

   localparam int AdcW   = 8;
   localparam int GainW  = 9;
   localparam int DistW  = 16;
   localparam int SpeedW = 21;
   localparam int TtcW   = 16;
   localparam int ClassW = 2;
   localparam int MvW    = 13;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 16;

   // shared divider sizes: numerator covers distance * 512 plus speed
   localparam int DivNumW = 26;
   localparam int DivDenW = 21;
   localparam int DivCntW = $clog2(DivNumW);

   // register indexes of the write port
   typedef enum logic [CsrIdxW-1:0] {
      CSR_DIST_GAIN  = 3'd0,
      CSR_SPEED_GAIN = 3'd1,
      CSR_FAR        = 3'd2,
      CSR_NEAR       = 3'd3,
      CSR_HYST       = 3'd4,
      CSR_INVALID    = 3'd5,
      CSR_VALID      = 3'd6
   } csr_idx_type;

   typedef enum logic [ClassW-1:0] {
      OBJ_NONE    = 2'd0,
      OBJ_FAR     = 2'd1,
      OBJ_NEAR    = 2'd2,
      OBJ_INVALID = 2'd3
   } obj_type;

   typedef enum logic [ClassW-1:0] {
      ALERT_NONE    = 2'd0,
      ALERT_DETECT  = 2'd1,
      ALERT_COLLIDE = 2'd2,
      ALERT_WARN    = 2'd3
   } alert_type;

   typedef struct packed {
      logic [GainW-1:0] distance_gain;
      logic [GainW-1:0] speed_gain;
      logic [DistW-1:0] far_threshold;
      logic [DistW-1:0] near_threshold;
      logic [DistW-1:0] hysteresis_margin;
      logic [DistW-1:0] invalid_threshold;
      logic [DistW-1:0] valid_threshold;
   } cfg_type;

   typedef struct packed {
      logic               start;
      logic [DivNumW-1:0] num;
      logic [DivDenW-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DivNumW-1:0] quo;
   } div_rsp_type;

   // converter code to millivolts, floor(code * 5000 / 255)
   typedef logic [MvW-1:0] mv_lut_type [256];

   function automatic mv_lut_type build_mv_lut();
      mv_lut_type lut;
      for (int i = 0; i < 256; i++) begin
         lut[i] = MvW'((i * 5000) / 255);
      end
      return lut;
   endfunction

   localparam mv_lut_type MvLut = build_mv_lut();

endpackage

[rtl/core/rscm_ifs.sv]
// Channel interfaces: sample input, result output and register write port.
`timescale 1ns / 1ps

interface rscm_req_if;
   logic                        valid;
   logic                        ready;
   logic                        op;
   logic [rscm_pkg::AdcW-1:0]   adc_sample;
   modport source (output valid, op, adc_sample, input ready);
   modport sink   (input valid, op, adc_sample, output ready);
endinterface

interface rscm_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [rscm_pkg::DistW-1:0]         distance_cm;
   logic signed [rscm_pkg::SpeedW-1:0] speed_cms;
   logic [rscm_pkg::TtcW-1:0]          ttc_seconds;
   logic [rscm_pkg::ClassW-1:0]        object_class;
   logic [rscm_pkg::ClassW-1:0]        alert_level;
   modport source (output valid, distance_cm, speed_cms, ttc_seconds, object_class,
                   alert_level, input ready);
   modport sink   (input valid, distance_cm, speed_cms, ttc_seconds, object_class,
                   alert_level, output ready);
endinterface

interface rscm_csr_if;
   logic                          valid;
   logic                          ready;
   logic [rscm_pkg::CsrIdxW-1:0]  reg_index;
   logic [rscm_pkg::CsrDataW-1:0] wdata;
   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

[rtl/core/rscm_csr.sv]
// Configuration register file.
`timescale 1ns / 1ps

module rscm_csr (
   input  logic              clock,
   input  logic              reset,
   rscm_csr_if.sink          csr_bus,
   output rscm_pkg::cfg_type cfg
);

   rscm_pkg::cfg_type cfg_ff;

   assign csr_bus.ready = 1'b1;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.distance_gain     <= 9'd128;
         cfg_ff.speed_gain        <= 9'd128;
         cfg_ff.far_threshold     <= 16'd1600;
         cfg_ff.near_threshold    <= 16'd800;
         cfg_ff.hysteresis_margin <= 16'd80;
         cfg_ff.invalid_threshold <= 16'd160;
         cfg_ff.valid_threshold   <= 16'd240;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.reg_index)
            rscm_pkg::CSR_DIST_GAIN: begin
               cfg_ff.distance_gain <= csr_bus.wdata[rscm_pkg::GainW-1:0];
            end
            rscm_pkg::CSR_SPEED_GAIN: begin
               cfg_ff.speed_gain <= csr_bus.wdata[rscm_pkg::GainW-1:0];
            end
            rscm_pkg::CSR_FAR:     cfg_ff.far_threshold     <= csr_bus.wdata;
            rscm_pkg::CSR_NEAR:    cfg_ff.near_threshold    <= csr_bus.wdata;
            rscm_pkg::CSR_HYST:    cfg_ff.hysteresis_margin <= csr_bus.wdata;
            rscm_pkg::CSR_INVALID: cfg_ff.invalid_threshold <= csr_bus.wdata;
            rscm_pkg::CSR_VALID:   cfg_ff.valid_threshold   <= csr_bus.wdata;
            default: begin
            end
         endcase
      end
   end

endmodule

[rtl/core/rscm_div.sv]
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module rscm_div (
   input  logic                  clock,
   input  logic                  reset,
   input  rscm_pkg::div_req_type div_req,
   output rscm_pkg::div_rsp_type div_rsp
);

   localparam int NumW = rscm_pkg::DivNumW;
   localparam int DenW = rscm_pkg::DivDenW;
   localparam int CntW = rscm_pkg::DivCntW;

   logic            busy_ff;
   logic            done_ff;
   logic [CntW-1:0] cnt_ff;
   logic [DenW-1:0] rem_ff;
   logic [NumW-1:0] quo_ff;
   logic [DenW-1:0] den_ff;

   logic [DenW:0]   trial_in;
   logic [DenW:0]   diff_in;
   logic            fits_in;

   always_comb begin
      trial_in = {rem_ff, quo_ff[NumW-1]};
      diff_in  = trial_in - {1'b0, den_ff};
      fits_in  = trial_in >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            quo_ff  <= div_req.num;
            den_ff  <= div_req.den;
         end else if (busy_ff) begin
            rem_ff <= fits_in ? diff_in[DenW-1:0] : trial_in[DenW-1:0];
            quo_ff <= {quo_ff[NumW-2:0], fits_in};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CntW'(NumW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = quo_ff;

endmodule

[rtl/core/range_sensor_collision_monitor_unit.sv]
// Top level of the range sensor collision monitor: sequencer and datapath.
`timescale 1ns / 1ps
// Divider use: each accepted word passes through the 26-step shared
//   divider up to twice: one pass for distance (skipped at zero volts),
//   one for time-to-collision (only while speed is negative).
// Input: a new word is taken the cycle after the result is loaded
//   into the output register.
// Reset: synchronous, clears sequencer, filter state, output valid and
//   restores register defaults; collision time resets to its maximum.

module range_sensor_collision_monitor_unit (
   input  logic       clock,
   input  logic       reset,
   rscm_req_if.sink   req_bus,
   rscm_rsp_if.source rsp_bus,
   rscm_csr_if.sink   csr_bus
);

   localparam int DistW  = rscm_pkg::DistW;
   localparam int SpeedW = rscm_pkg::SpeedW;
   localparam int GainW  = rscm_pkg::GainW;
   localparam int MvW    = rscm_pkg::MvW;
   localparam int NumW   = rscm_pkg::DivNumW;
   localparam int DenW   = rscm_pkg::DivDenW;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RAW_START,
      ST_RAW_WAIT,
      ST_DIST_MUL,
      ST_DIST_SUM,
      ST_TTC_START,
      ST_TTC_WAIT,
      ST_CLASSIFY,
      ST_ALERT,
      ST_VEL_MUL,
      ST_SPD_MUL,
      ST_SPD_SUM,
      ST_DONE
   } state_type;

   // distance filter only follows small steps (30 cm in Q12.4)
   localparam logic [DistW:0]  CloseLimit = 17'd480;
   localparam logic [GainW-1:0] GainOne   = 9'd256;
   localparam logic signed [31:0] Round8  = 32'sd128;
   localparam logic signed [31:0] SpeedLimit = 32'sd655360;
   localparam logic [DistW-1:0] TtcDetect  = 16'd2560;   // 10 s
   localparam logic [DistW-1:0] TtcCollide = 16'd1280;   // 5 s

   rscm_pkg::cfg_type     cfg;
   rscm_pkg::div_req_type div_req;
   rscm_pkg::div_rsp_type div_rsp;

   state_type               state_ff;
   logic                    op_ff;
   logic [MvW-1:0]          mv_ff;
   logic [DistW-1:0]        raw_ff;
   logic [DistW-1:0]        prev_ff;
   logic [DistW-1:0]        fd_ff;
   logic signed [SpeedW-1:0] fs_ff;
   logic signed [SpeedW-1:0] vel_ff;
   logic [DistW-1:0]        ttc_ff;
   rscm_pkg::obj_type       obj_ff;
   rscm_pkg::alert_type     alert_ff;
   logic signed [31:0]      acc_ff;

   logic                    rsp_valid_ff;
   logic [DistW-1:0]        out_dist_ff;
   logic signed [SpeedW-1:0] out_speed_ff;
   logic [DistW-1:0]        out_ttc_ff;
   rscm_pkg::obj_type       out_obj_ff;
   rscm_pkg::alert_type     out_alert_ff;

   logic                    req_fire;
   logic                    out_free;

   logic [GainW-1:0]        dg_eff, dg_inv, sg_eff, sg_inv;
   logic signed [21:0]      mul_a;
   logic signed [9:0]       mul_b;
   logic signed [31:0]      mul_prod;
   logic signed [31:0]      sum_in;
   logic signed [31:0]      spd_shift;
   logic signed [DistW:0]   raw_step;
   logic [DistW:0]          dist_abs;
   logic signed [DistW:0]   move_diff;
   logic [DistW-1:0]        fd_in;
   logic signed [SpeedW-1:0] fs_in;
   logic [SpeedW-1:0]       fs_neg;
   logic [DistW-1:0]        quo_sat;
   rscm_pkg::obj_type       obj_in;
   rscm_pkg::alert_type     alert_in;
   logic signed [DistW+1:0] d_s, far_lo, far_hi, near_lo, near_hi, inv_s, val_s;

   rscm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   rscm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   // gains above one act as one
   always_comb begin
      dg_eff = (cfg.distance_gain > GainOne) ? GainOne : cfg.distance_gain;
      sg_eff = (cfg.speed_gain > GainOne) ? GainOne : cfg.speed_gain;
      dg_inv = GainOne - dg_eff;
      sg_inv = GainOne - sg_eff;
   end

   // divider operands: raw distance, then time-to-collision
   always_comb begin
      fs_neg        = SpeedW'(-fs_ff);
      div_req.start = 1'b0;
      div_req.num   = NumW'(640000) + NumW'(mv_ff[MvW-1:1]);
      div_req.den   = DenW'(mv_ff);
      if (state_ff == ST_RAW_START) begin
         div_req.start = (mv_ff != '0);
      end else if (state_ff == ST_TTC_START) begin
         div_req.start = fs_ff[SpeedW-1];
         div_req.num   = {1'b0, fd_ff, 9'b0} + NumW'(fs_neg);
         div_req.den   = {fs_neg[DenW-2:0], 1'b0};
      end
      quo_sat = (|div_rsp.quo[NumW-1:DistW]) ? '1 : div_rsp.quo[DistW-1:0];
   end

   // the one multiplier, steered by the sequencer
   always_comb begin
      move_diff = $signed({1'b0, fd_ff}) - $signed({1'b0, prev_ff});
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_DIST_MUL: begin
            mul_a = $signed({6'b0, raw_ff});
            mul_b = $signed({1'b0, dg_eff});
         end
         ST_DIST_SUM: begin
            mul_a = $signed({6'b0, prev_ff});
            mul_b = $signed({1'b0, dg_inv});
         end
         ST_VEL_MUL: begin
            mul_a = 22'(move_diff);
            mul_b = 10'sd10;
         end
         ST_SPD_MUL: begin
            mul_a = 22'(vel_ff);
            mul_b = $signed({1'b0, sg_eff});
         end
         ST_SPD_SUM: begin
            mul_a = 22'(fs_ff);
            mul_b = $signed({1'b0, sg_inv});
         end
         default: begin
         end
      endcase
      mul_prod = mul_a * mul_b;
      sum_in   = acc_ff + mul_prod + Round8;
   end

   // distance filter gate and speed saturation
   always_comb begin
      raw_step  = $signed({1'b0, raw_ff}) - $signed({1'b0, prev_ff});
      dist_abs  = raw_step[DistW] ? (DistW+1)'(-raw_step) : (DistW+1)'(raw_step);
      fd_in     = (dist_abs < CloseLimit) ? sum_in[DistW+7:8] : raw_ff;
      spd_shift = sum_in >>> 8;
      if (spd_shift > SpeedLimit) begin
         fs_in = SpeedW'(SpeedLimit);
      end else if (spd_shift < -SpeedLimit) begin
         fs_in = SpeedW'(-SpeedLimit);
      end else begin
         fs_in = spd_shift[SpeedW-1:0];
      end
   end

   // hysteresis classifier; margin may push a limit below zero
   always_comb begin
      d_s     = $signed({2'b0, fd_ff});
      far_lo  = $signed({2'b0, cfg.far_threshold}) - $signed({2'b0, cfg.hysteresis_margin});
      far_hi  = $signed({2'b0, cfg.far_threshold}) + $signed({2'b0, cfg.hysteresis_margin});
      near_lo = $signed({2'b0, cfg.near_threshold}) - $signed({2'b0, cfg.hysteresis_margin});
      near_hi = $signed({2'b0, cfg.near_threshold}) + $signed({2'b0, cfg.hysteresis_margin});
      inv_s   = $signed({2'b0, cfg.invalid_threshold});
      val_s   = $signed({2'b0, cfg.valid_threshold});
      obj_in  = obj_ff;
      unique case (obj_ff)
         rscm_pkg::OBJ_NONE: begin
            if (d_s < far_lo) obj_in = rscm_pkg::OBJ_FAR;
         end
         rscm_pkg::OBJ_FAR: begin
            if (d_s < near_lo)     obj_in = rscm_pkg::OBJ_NEAR;
            else if (d_s > far_hi) obj_in = rscm_pkg::OBJ_NONE;
         end
         rscm_pkg::OBJ_NEAR: begin
            if (d_s < inv_s)        obj_in = rscm_pkg::OBJ_INVALID;
            else if (d_s > near_hi) obj_in = rscm_pkg::OBJ_FAR;
         end
         rscm_pkg::OBJ_INVALID: begin
            if (d_s > val_s) obj_in = rscm_pkg::OBJ_NEAR;
         end
         default: begin
         end
      endcase
   end

   // alert from the freshly classified object and collision time
   always_comb begin
      alert_in = alert_ff;
      unique case (obj_ff) inside
         rscm_pkg::OBJ_NONE: alert_in = rscm_pkg::ALERT_NONE;
         rscm_pkg::OBJ_FAR, rscm_pkg::OBJ_NEAR: begin
            if (ttc_ff > TtcDetect)       alert_in = rscm_pkg::ALERT_DETECT;
            else if (ttc_ff > TtcCollide) alert_in = rscm_pkg::ALERT_COLLIDE;
            else                          alert_in = rscm_pkg::ALERT_WARN;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         prev_ff      <= '0;
         fd_ff        <= '0;
         fs_ff        <= '0;
         ttc_ff       <= '1;
         obj_ff       <= rscm_pkg::OBJ_NONE;
         alert_ff     <= rscm_pkg::ALERT_NONE;
      end else begin
         // output register: load from the final state, else drain on ready
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  op_ff    <= req_bus.op;
                  mv_ff    <= rscm_pkg::MvLut[req_bus.adc_sample];
                  prev_ff  <= fd_ff;
                  state_ff <= ST_RAW_START;
               end
            end
            ST_RAW_START: begin
               if (mv_ff == '0) begin
                  raw_ff   <= '1;          // zero volts: distance saturates
                  state_ff <= ST_DIST_MUL;
               end else begin
                  state_ff <= ST_RAW_WAIT;
               end
            end
            ST_RAW_WAIT: begin
               if (div_rsp.done) begin
                  raw_ff   <= quo_sat;
                  state_ff <= ST_DIST_MUL;
               end
            end
            ST_DIST_MUL: begin
               acc_ff   <= mul_prod;
               state_ff <= ST_DIST_SUM;
            end
            ST_DIST_SUM: begin
               fd_ff    <= fd_in;
               state_ff <= ST_TTC_START;
            end
            ST_TTC_START: begin
               // collision time holds unless closing
               state_ff <= fs_ff[SpeedW-1] ? ST_TTC_WAIT : ST_CLASSIFY;
            end
            ST_TTC_WAIT: begin
               if (div_rsp.done) begin
                  ttc_ff   <= quo_sat;
                  state_ff <= ST_CLASSIFY;
               end
            end
            ST_CLASSIFY: begin
               obj_ff   <= obj_in;
               state_ff <= ST_ALERT;
            end
            ST_ALERT: begin
               alert_ff <= alert_in;
               state_ff <= op_ff ? ST_VEL_MUL : ST_DONE;
            end
            ST_VEL_MUL: begin
               vel_ff   <= mul_prod[SpeedW-1:0];   // step * 10 per 100 ms
               state_ff <= ST_SPD_MUL;
            end
            ST_SPD_MUL: begin
               acc_ff   <= mul_prod;
               state_ff <= ST_SPD_SUM;
            end
            ST_SPD_SUM: begin
               fs_ff    <= fs_in;
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (out_free) begin
                  out_dist_ff  <= fd_ff;
                  out_speed_ff <= fs_ff;
                  out_ttc_ff   <= ttc_ff;
                  out_obj_ff   <= obj_ff;
                  out_alert_ff <= alert_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.distance_cm  = out_dist_ff;
   assign rsp_bus.speed_cms    = out_speed_ff;
   assign rsp_bus.ttc_seconds  = out_ttc_ff;
   assign rsp_bus.object_class = out_obj_ff;
   assign rsp_bus.alert_level  = out_alert_ff;

   // divider answers only while the sequencer waits on it
   a_div_done_in_wait : assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_RAW_WAIT || state_ff == ST_TTC_WAIT))
      else $error("divider result outside a wait state");

   // an accepted word closes the input until its result is out
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_bus.ready)
      else $error("input open while a word is in work");

   // result word only ever launched from the final state
   a_rsp_from_done : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result word raised outside the final state");

   // filtered speed stays inside its saturation band
   a_speed_band : assert property (@(posedge clock) disable iff (reset)
      (fs_ff <= 21'sd655360) && (fs_ff >= -21'sd655360))
      else $error("filtered speed outside its limits");

endmodule
